// File: src/f2dt_pkg.sv
package f2dt_pkg;

	localparam int FLOAT_W = 32;
	localparam int CHAR_W = 7;
	localparam int THOU_W = 24;
	localparam int PROD_W = 34;
	localparam int NUM_DIGITS = 7;

	localparam logic [7:0] EXP_SPECIAL = 8'hFF;
	localparam logic [7:0] SUBNORM_SHIFT = 8'd149;
	localparam logic [7:0] NORM_SHIFT_BASE = 8'd150;
	localparam logic [7:0] SHIFT_ZERO_LIMIT = 8'd40;
	localparam logic [30:0] OVF_LIMIT = 31'h461C3FFF;
	localparam logic [9:0] SCALE = 10'd1000;

	// x / 10 == (x * RECIP10) >> RECIP_SHIFT for every x below 2**26.
	localparam logic [23:0] RECIP10 = 24'hCCCCCD;
	localparam int RECIP_SHIFT = 27;

	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
	localparam logic [2:0] CH_DIGIT_HI = 3'b011;
	localparam logic [CHAR_W-1:0] CH_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_F = 7'h66;
	localparam logic [CHAR_W-1:0] CH_I = 7'h69;
	localparam logic [CHAR_W-1:0] CH_N = 7'h6E;
	localparam logic [CHAR_W-1:0] CH_O = 7'h6F;
	localparam logic [CHAR_W-1:0] CH_V = 7'h76;

	typedef enum logic [1:0] {
		CLS_NUM = 2'd0,
		CLS_NAN = 2'd1,
		CLS_INF = 2'd2,
		CLS_OVF = 2'd3
	} cls_t;

	typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

	// Classified value with its magnitude scaled to thousandths.
	typedef struct packed {
		cls_t cls;
		logic neg;
		logic [THOU_W-1:0] thou;
	} fixed_t;

	// Queue entry: digit 0 is the thousandths digit, digit 6 the thousands digit.
	typedef struct packed {
		cls_t cls;
		logic neg;
		digits_t digits;
	} entry_t;

endpackage

// File: src/f2dt_in_if.sv
interface f2dt_in_if;
	logic valid;
	logic ready;
	logic [f2dt_pkg::FLOAT_W-1:0] float_bits;

	modport source(output valid, output float_bits, input ready);
	modport sink(input valid, input float_bits, output ready);
endinterface

// File: src/f2dt_out_if.sv
interface f2dt_out_if;
	logic valid;
	logic ready;
	logic [f2dt_pkg::CHAR_W-1:0] text_char;
	logic last_char;

	modport source(output valid, output text_char, output last_char, input ready);
	modport sink(input valid, input text_char, input last_char, output ready);
endinterface

// File: src/float_to_decimal_text.sv
// Formats IEEE-754 single-precision values as ASCII text. Each value taken on
// the value channel gives a run of 4 to 9 characters on the text channel, one
// character per transaction, with last_char set on the final one: " nan" for
// any NaN, " inf" or "-inf" for infinity, a sign character (' ' or '-') and
// "ovf" when the magnitude exceeds 9999.9990234375, and otherwise a sign
// character, the integer part without leading zeros, a point and three
// fraction digits, the magnitude rounded half-up to thousandths exactly
// (negative zero prints "-0.000"). A three-stage front end registers the
// value, scales it by 1000 and rounds it; a decimal converter then splits it
// into digits, one digit per cycle, and takes the next value as it hands a
// result on. Results wait in a queue of QUEUE_DEPTH entries, and the back
// end emits one character per cycle from a registered output while the
// receiver is ready. New values are taken while earlier ones are still being
// converted or printed. Both channels stall independently without loss.
module float_to_decimal_text #(
	parameter int QUEUE_DEPTH = 2 // result queue entries, 2 or more
) (
	input logic clk,
	input logic arst_n,
	f2dt_in_if.sink value,
	f2dt_out_if.source text
);
	import f2dt_pkg::*;

	logic fx_valid, fx_ready;
	fixed_t fx;
	logic cv_valid, cv_ready;
	entry_t cv_entry;
	logic q_valid, q_pop;
	entry_t q_entry;

	// Classification, scaling by 1000 and rounding to thousandths.
	f2dt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.value(value),
		.fx_valid(fx_valid),
		.fx(fx),
		.fx_ready(fx_ready)
	);

	// Binary to decimal digits, one digit per cycle.
	f2dt_digits u_digits (
		.clk(clk),
		.arst_n(arst_n),
		.fx_valid(fx_valid),
		.fx(fx),
		.fx_ready(fx_ready),
		.ent_valid(cv_valid),
		.ent(cv_entry),
		.ent_ready(cv_ready)
	);

	// Decouples the conversion from character emission.
	f2dt_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(cv_valid),
		.push_data(cv_entry),
		.push_ready(cv_ready),
		.pop_valid(q_valid),
		.pop_data(q_entry),
		.pop(q_pop)
	);

	// Character sequencer and output register.
	f2dt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ent_valid(q_valid),
		.ent(q_entry),
		.pop(q_pop),
		.text(text)
	);

endmodule

// File: src/f2dt_front.sv
module f2dt_front (
	input logic clk,
	input logic arst_n,
	f2dt_in_if.sink value,
	output logic fx_valid,
	output f2dt_pkg::fixed_t fx,
	input logic fx_ready
);
	import f2dt_pkg::*;

	logic en1, en2, en3;
	logic v1_q, v2_q, v3_q;
	logic [FLOAT_W-1:0] bits_s1;

	logic [7:0] expf;
	logic [22:0] mant;
	logic [23:0] sig;
	logic [7:0] shift;
	cls_t cls_d;
	logic [PROD_W-1:0] prod;

	cls_t cls_s2;
	logic neg_s2;
	logic zero_s2;
	logic [5:0] sh_s2;
	logic [PROD_W-1:0] prod_s2;

	logic [PROD_W-1:0] scaled;
	logic [25:0] rounded;
	fixed_t fx_s3;

	assign en3 = !v3_q || fx_ready;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign value.ready = en1;

	assign expf = bits_s1[30:23];
	assign mant = bits_s1[22:0];

	always_comb begin
		if (expf == EXP_SPECIAL) begin
			cls_d = (mant != '0) ? CLS_NAN : CLS_INF;
		end else if (bits_s1[30:0] > OVF_LIMIT) begin
			cls_d = CLS_OVF;
		end else begin
			cls_d = CLS_NUM;
		end
		if (expf == '0) begin
			sig = {1'b0, mant};
			shift = SUBNORM_SHIFT;
		end else begin
			sig = {1'b1, mant};
			shift = NORM_SHIFT_BASE - expf;
		end
	end

	assign prod = PROD_W'(sig) * PROD_W'(SCALE);

	// Round half up: floor(p / 2^s + 1/2) == (floor(p / 2^(s-1)) + 1) >> 1.
	assign scaled = prod_s2 >> sh_s2;
	assign rounded = {1'b0, scaled[24:0]} + 26'd1;

	always_comb begin
		fx_s3.cls = cls_s2;
		fx_s3.neg = neg_s2;
		fx_s3.thou = zero_s2 ? '0 : rounded[THOU_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= value.valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && value.valid) begin
			bits_s1 <= value.float_bits;
		end
		if (en2 && v1_q) begin
			cls_s2 <= cls_d;
			neg_s2 <= bits_s1[31];
			zero_s2 <= (shift >= SHIFT_ZERO_LIMIT);
			sh_s2 <= 6'(shift - 8'd1);
			prod_s2 <= prod;
		end
		if (en3 && v2_q) begin
			fx <= fx_s3;
		end
	end

	assign fx_valid = v3_q;

endmodule

// File: src/f2dt_digits.sv
module f2dt_digits (
	input logic clk,
	input logic arst_n,
	input logic fx_valid,
	input f2dt_pkg::fixed_t fx,
	output logic fx_ready,
	output logic ent_valid,
	output f2dt_pkg::entry_t ent,
	input logic ent_ready
);
	import f2dt_pkg::*;

	typedef enum logic [2:0] {
		CV_IDLE = 3'b001,
		CV_RUN = 3'b010,
		CV_DONE = 3'b100
	} cv_state_t;

	localparam int CNT_W = $clog2(NUM_DIGITS);
	localparam int Q_W = 2 * THOU_W - RECIP_SHIFT;

	cv_state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [THOU_W-1:0] x_q;
	cls_t cls_q;
	logic neg_q;
	digits_t digits_q;

	logic load;
	logic [2*THOU_W-1:0] recip_prod;
	logic [Q_W-1:0] quot;
	logic [THOU_W-1:0] quot10;
	logic [THOU_W-1:0] rem;

	assign fx_ready = (state_q == CV_IDLE) || (state_q == CV_DONE && ent_ready);
	assign load = fx_valid && fx_ready;

	// One decimal digit per cycle, least significant first.
	assign recip_prod = (2*THOU_W)'(x_q) * (2*THOU_W)'(RECIP10);
	assign quot = recip_prod[2*THOU_W-1:RECIP_SHIFT];
	assign quot10 = THOU_W'({quot, 3'b000}) + THOU_W'({quot, 1'b0});
	assign rem = x_q - quot10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CV_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				CV_IDLE: begin
					if (load) begin
						state_q <= (fx.cls == CLS_NUM) ? CV_RUN : CV_DONE;
						cnt_q <= '0;
					end
				end
				CV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_DIGITS - 1)) begin
						state_q <= CV_DONE;
					end
				end
				CV_DONE: begin
					if (load) begin
						state_q <= (fx.cls == CLS_NUM) ? CV_RUN : CV_DONE;
						cnt_q <= '0;
					end else if (ent_ready) begin
						state_q <= CV_IDLE;
					end
				end
				default: begin
					state_q <= CV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= fx.thou;
			cls_q <= fx.cls;
			neg_q <= fx.neg;
		end else if (state_q == CV_RUN) begin
			x_q <= THOU_W'(quot);
			digits_q <= {rem[3:0], digits_q[NUM_DIGITS-1:1]};
		end
	end

	assign ent_valid = (state_q == CV_DONE);

	always_comb begin
		ent.cls = cls_q;
		ent.neg = neg_q;
		ent.digits = digits_q;
	end

endmodule

// File: src/f2dt_fifo.sv
module f2dt_fifo #(
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input f2dt_pkg::entry_t push_data,
	output logic push_ready,
	output logic pop_valid,
	output f2dt_pkg::entry_t pop_data,
	input logic pop
);
	import f2dt_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// File: src/f2dt_back.sv
module f2dt_back (
	input logic clk,
	input logic arst_n,
	input logic ent_valid,
	input f2dt_pkg::entry_t ent,
	output logic pop,
	f2dt_out_if.source text
);
	import f2dt_pkg::*;

	logic [3:0] pos_q;
	logic out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic last_q;

	logic [3:0] nw;
	logic [3:0] len;
	logic [3:0] idx;
	logic [3:0] digit;
	logic [CHAR_W-1:0] sign_char;
	logic [CHAR_W-1:0] char_d;
	logic last_d;
	logic fire;

	assign sign_char = ent.neg ? CH_MINUS : CH_SPACE;

	// Number of integer digits printed, leading zeros dropped.
	always_comb begin
		if (ent.digits[6] != '0) begin
			nw = 4'd4;
		end else if (ent.digits[5] != '0) begin
			nw = 4'd3;
		end else if (ent.digits[4] != '0) begin
			nw = 4'd2;
		end else begin
			nw = 4'd1;
		end
	end

	assign len = (ent.cls == CLS_NUM) ? nw + 4'd5 : 4'd4;
	assign last_d = (pos_q == len - 4'd1);

	always_comb begin
		if (pos_q <= nw) begin
			idx = 4'd3 + nw - pos_q;
		end else begin
			idx = nw + 4'd4 - pos_q;
		end
		digit = ent.digits[idx[2:0]];
	end

	always_comb begin
		char_d = CH_SPACE;
		unique case (ent.cls)
			CLS_NAN: begin
				unique case (pos_q)
					4'd1: char_d = CH_N;
					4'd2: char_d = CH_A;
					4'd3: char_d = CH_N;
					default: char_d = CH_SPACE;
				endcase
			end
			CLS_INF: begin
				unique case (pos_q)
					4'd0: char_d = sign_char;
					4'd1: char_d = CH_I;
					4'd2: char_d = CH_N;
					default: char_d = CH_F;
				endcase
			end
			CLS_OVF: begin
				unique case (pos_q)
					4'd0: char_d = sign_char;
					4'd1: char_d = CH_O;
					4'd2: char_d = CH_V;
					default: char_d = CH_F;
				endcase
			end
			CLS_NUM: begin
				if (pos_q == 4'd0) begin
					char_d = sign_char;
				end else if (pos_q == nw + 4'd1) begin
					char_d = CH_POINT;
				end else begin
					char_d = {CH_DIGIT_HI, digit};
				end
			end
			default: char_d = CH_SPACE;
		endcase
	end

	assign fire = ent_valid && (!out_valid_q || text.ready);
	assign pop = fire && last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pos_q <= last_d ? '0 : pos_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

	assign text.valid = out_valid_q;
	assign text.text_char = char_q;
	assign text.last_char = last_q;

endmodule

// File: test/tb_float_to_decimal_text.sv
`timescale 1ns / 100ps

// Keeps the expected character stream of the formatter and checks every character
// that leaves the text channel against it.
class text_scoreboard;

	typedef struct packed {
		logic [f2dt_pkg::CHAR_W-1:0] text_char;
		logic last_char;
	} text_item_t;

	// The largest magnitude that still prints as digits: 9999.9990234375.
	localparam logic [30:0] LARGEST_PRINTABLE = 31'h461C3FFF;

	text_item_t pending_chars[$];
	int errors = 0;

	task report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// Works out the text of one accepted value and queues its characters.
	function void note_value(input logic [31:0] bits);
		logic sign;
		logic [7:0] expo;
		logic [22:0] mant;
		logic [63:0] sig;
		logic [63:0] scaled;
		int unsigned shift;
		int unsigned whole;
		int unsigned milli;
		string txt;
		byte c;
		text_item_t item;

		sign = bits[31];
		expo = bits[30:23];
		mant = bits[22:0];
		if (expo == 8'hFF) begin
			txt = (mant != 0) ? " nan" : (sign ? "-inf" : " inf");
		end else begin
			txt = sign ? "-" : " ";
			if (bits[30:0] > LARGEST_PRINTABLE) begin
				txt = {txt, "ovf"};
			end else begin
				// Exact half-up rounding to thousandths: scale the significand by
				// 1000, add half an LSB of the shift and drop the shifted bits.
				if (expo == 8'd0) begin
					sig = {41'd0, mant};
					shift = 149;
				end else begin
					sig = {40'd0, 1'b1, mant};
					shift = 150 - int'(expo);
				end
				if (shift >= 40)
					scaled = 64'd0;
				else
					scaled = (sig * 64'd1000 + (64'd1 << (shift - 1))) >> shift;
				whole = scaled[31:0] / 1000;
				milli = scaled[31:0] % 1000;
				txt = {txt, $sformatf("%0d.%03d", whole, milli)};
			end
		end

		for (int i = 0; i < txt.len(); i++) begin
			c = txt[i];
			item.text_char = c[6:0];
			item.last_char = (i == txt.len() - 1);
			pending_chars.push_back(item);
		end
	endfunction

	task check_char(input logic [f2dt_pkg::CHAR_W-1:0] text_char, input logic last_char);
		text_item_t want;

		if (pending_chars.size() == 0) begin
			report_mismatch($sformatf("unexpected character 0x%02h ('%c')", text_char,
				text_char));
		end else begin
			want = pending_chars.pop_front();
			if (text_char !== want.text_char)
				report_mismatch($sformatf("text_char 0x%02h ('%c'), expected 0x%02h ('%c')",
					text_char, text_char, want.text_char, want.text_char));
			if (last_char !== want.last_char)
				report_mismatch($sformatf("last_char %b on '%c', expected %b", last_char,
					text_char, want.last_char));
		end
	endtask

endclass

module tb_float_to_decimal_text;

	// This bound only catches a hang.
	localparam int CYCLE_LIMIT = 200000;
	// Covers any stray character that would follow the last expected one.
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	f2dt_in_if value_ch();
	f2dt_out_if text_ch();

	float_to_decimal_text uut (
		.clk(clk),
		.arst_n(arst_n),
		.value(value_ch),
		.text(text_ch)
	);

	text_scoreboard sb = new();

	// Percentages of cycles in which the sender holds back valid and the receiver
	// holds back ready. The main sequence changes them phase by phase.
	int send_idle_pct = 7;
	int recv_idle_pct = 64;
	int cycle_count = 0;

	// Corner values: both zeros, both infinities, NaNs with the smallest and the
	// largest payload and either sign, the overflow threshold on both sides,
	// the largest finite value, subnormals, an exact half thousandth that must
	// round up, each integer-part length, and the exponents around the point
	// where the scaled magnitude is forced to zero.
	logic [31:0] corner_values [0:24] = '{
		32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
		32'hFFFFFFFF, 32'h7F800001, 32'h461C3FFF, 32'hC61C3FFF, 32'h461C4000,
		32'hC61C4000, 32'h7F7FFFFF, 32'h00000001, 32'h807FFFFF, 32'h3F800000,
		32'hBFC00000, 32'h3D800000, 32'h3A03126F, 32'h3A83126F, 32'h41200000,
		32'h42C80000, 32'h447A0000, 32'hC2F6E979, 32'h37000000, 32'h37800000
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Mostly printable magnitudes with random digits, since those exercise the
	// rounding and the digit split. The rest covers tiny values, the overflow
	// edge, NaN and infinity, plain overflow and fully random patterns.
	function automatic logic [31:0] random_value();
		int pick;
		logic sign;
		logic [7:0] expo;
		logic [31:0] mant;
		int offset;

		pick = $urandom_range(99);
		sign = $urandom_range(1);
		mant = $urandom();
		if (pick < 50) begin
			expo = $urandom_range(140, 117);
		end else if (pick < 65) begin
			expo = $urandom_range(116, 0);
		end else if (pick < 75) begin
			// Within a few ULPs of the threshold on either side.
			offset = int'($urandom_range(16)) - 8;
			return {sign, 31'(32'h461C3FFF + offset)};
		end else if (pick < 85) begin
			return $urandom();
		end else if (pick < 95) begin
			expo = 8'hFF;
			if ($urandom_range(3) == 0)
				mant = 32'd0;
		end else begin
			expo = $urandom_range(254, 141);
		end
		return {sign, expo, mant[22:0]};
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_value(input logic [31:0] bits);
		while ($urandom_range(99) < send_idle_pct) begin
			value_ch.valid = 1'b0;
			@(negedge clk);
		end
		value_ch.valid = 1'b1;
		value_ch.float_bits = bits;
		do @(posedge clk); while (!value_ch.ready);
		sb.note_value(bits);
		@(negedge clk);
	endtask

	task automatic wait_until_drained();
		while (sb.pending_chars.size() != 0)
			@(negedge clk);
	endtask

	// Receiver: decides ready at each falling edge and checks at the rising edge.
	initial begin
		text_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			text_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (text_ch.valid && text_ch.ready)
				sb.check_char(text_ch.text_char, text_ch.last_char);
		end
	end

	initial begin
		value_ch.valid = 1'b0;
		value_ch.float_bits = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed corners with a light sender and a slow receiver.
		foreach (corner_values[i])
			send_value(corner_values[i]);
		value_ch.valid = 1'b0;

		// Let the block run completely dry once before the random part starts.
		wait_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		for (int i = 0; i < 60; i++)
			send_value(random_value());

		// Now the sender is the slow side and the receiver keeps up.
		send_idle_pct = 64;
		recv_idle_pct = 7;
		for (int i = 0; i < 62; i++)
			send_value(random_value());

		// Back-to-back transactions on both channels.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 63; i++)
			send_value(random_value());
		value_ch.valid = 1'b0;

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_chars.size() != 0)
			sb.report_mismatch($sformatf("%0d characters never arrived",
				sb.pending_chars.size()));

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
